// File: rtl/sbs_pkg.sv
// shared types, constants and a helper function for the spectrum bar smoother
package sbs_pkg;

	localparam int NUM_BARS = 256;
	localparam int BIN_W    = $clog2(NUM_BARS);
	localparam int MAG_W    = 16;
	localparam int DH_W     = 12;
	localparam int HGT_W    = 16;
	localparam int OUT_H_W  = 15;
	localparam int WGT_W    = $clog2(3200 * NUM_BARS + 1);
	localparam int E_W      = MAG_W + WGT_W;
	localparam int X_W      = E_W + 1;
	localparam int P_W      = $clog2(X_W);
	localparam int LG_W     = P_W + 16;
	localparam int SQ_CNT_W = 4;

	localparam logic [DH_W-1:0]  DH_RESET  = DH_W'(480);
	localparam logic [29:0]      KQ        = 30'd687813427;
	localparam logic [18:0]      SC        = 19'd513137;
	localparam logic [18:0]      RECIP3    = 19'd349526;
	localparam logic [15:0]      BIN_WGT   = 16'd3200;
	localparam logic [OUT_H_W-1:0] HMAX    = '1;
	localparam int               KQ_P      = 29;

	// log2 in Q.16, truncated, same squaring scheme as the datapath
	function automatic logic [LG_W-1:0] lg_const(input logic [63:0] x);
		logic [63:0] m;
		logic [15:0] frac;
		int          p;
		p = 0;
		frac = '0;
		for (int i = 0; i < 64; i++) begin
			if ((x >> i) != 64'd0) p = i;
		end
		if (p >= 30) m = x >> (p - 30);
		else m = x << (30 - p);
		for (int k = 15; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac[k] = 1'b1;
			end
		end
		return {P_W'(p), frac};
	endfunction

	localparam logic [LG_W-1:0] L0 = lg_const(64'(KQ));

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PROD = 8'b0000_0010,
		ST_NORM = 8'b0000_0100,
		ST_SQ   = 8'b0000_1000,
		ST_Y1   = 8'b0001_0000,
		ST_Y2   = 8'b0010_0000,
		ST_SUM  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} sbs_state_t;

	typedef struct packed {
		logic accept;
		logic prod;
		logic norm;
		logic sq;
		logic y1;
		logic y2;
		logic sum;
		logic fin;
	} sbs_cmd_t;

	typedef struct packed {
		logic out_busy;
	} sbs_stat_t;

endpackage

// File: rtl/sbs_ram.sv
// generic single-port-write, registered-read ram
module sbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

// File: rtl/sbs_ctrl.sv
// sequencing state machine for the bar smoother
module sbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sbs_pkg::sbs_stat_t stat,
	output sbs_pkg::sbs_cmd_t  cmd
);
	import sbs_pkg::*;

	sbs_state_t          state_q, state_d;
	logic [SQ_CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				cmd.norm = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq = 1'b1;
				if (cnt_q == '1) state_d = ST_Y1;
			end
			ST_Y1: begin
				cmd.y1 = 1'b1;
				state_d = ST_Y2;
			end
			ST_Y2: begin
				cmd.y2 = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!stat.out_busy) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQ) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end
endmodule

// File: rtl/sbs_dp.sv
// datapath: weighting, iterative log, diffusion, temporal blend, height store
module sbs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sbs_pkg::sbs_cmd_t             cmd,
	output sbs_pkg::sbs_stat_t            stat,
	input  logic                          cfg_valid,
	input  logic [sbs_pkg::DH_W-1:0]      cfg_data,
	input  logic [sbs_pkg::MAG_W-1:0]     magnitude,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sbs_pkg::BIN_W-1:0]     bar_index,
	output logic [sbs_pkg::OUT_H_W-1:0]   bar_height,
	output logic                          last_bar
);
	import sbs_pkg::*;

	logic [DH_W-1:0]    dh_q;
	logic [BIN_W-1:0]   bin_q;
	logic [HGT_W-1:0]   left_q;
	logic [NUM_BARS-1:0] valid_q;
	logic [MAG_W-1:0]   mag_q;
	logic [WGT_W-1:0]   wgt_q;
	logic [E_W-1:0]     e_q;
	logic [HGT_W-1:0]   right_q;
	logic [HGT_W-1:0]   old_q;
	logic [30:0]        m_q;
	logic [P_W-1:0]     p_q;
	logic [15:0]        frac_q;
	logic [31:0]        prod1_q;
	logic [31:0]        yq_q;
	logic [17:0]        t_q;
	logic               out_valid_q;
	logic [BIN_W-1:0]   idx_q;
	logic [OUT_H_W-1:0] hout_q;
	logic               last_q;

	logic               is_last;
	logic [BIN_W-1:0]   bin_nxt;
	logic [BIN_W-1:0]   rd_addr;
	logic [HGT_W-1:0]   rd_data;
	logic [X_W-1:0]     x;
	logic [P_W-1:0]     p;
	logic [X_W-1:0]     xn;
	logic [61:0]        sq;
	logic [31:0]        mt;
	logic [LG_W-1:0]    l1;
	logic [19:0]        dl;
	logic [51:0]        prod2;
	logic [31:0]        lft;
	logic [31:0]        rgt;
	logic [34:0]        s;
	logic [35:0]        n;
	logic [36:0]        hq;
	logic [16:0]        h;
	logic [OUT_H_W-1:0] h_sat;

	assign is_last = (bin_q == BIN_W'(NUM_BARS - 1));
	assign bin_nxt = bin_q + 1'b1;
	assign rd_addr = cmd.accept ? bin_nxt : bin_q;

	sbs_ram #(.WIDTH(HGT_W), .DEPTH(NUM_BARS)) u_store (
		.clk     (clk),
		.wr_en   (cmd.fin),
		.wr_addr (bin_q),
		.wr_data ({1'b0, h_sat}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// normalize so the leading one of x sits at bit 30 of the mantissa
	assign x = X_W'(KQ) + X_W'(e_q);
	always_comb begin
		p = P_W'(KQ_P);
		for (int i = KQ_P; i < X_W; i++) begin
			if (x[i]) p = P_W'(i);
		end
	end
	assign xn = x << (P_W'(X_W - 1) - p);

	assign sq = 62'(m_q) * 62'(m_q);
	assign mt = sq[61:30];

	assign l1 = {p_q, frac_q};
	assign dl = (l1 > L0) ? 20'(l1 - L0) : '0;
	assign prod2 = 52'(prod1_q) * 52'(SC);

	assign lft = (bin_q == '0) ? yq_q : {left_q, 16'd0};
	assign rgt = is_last ? yq_q : {right_q, 16'd0};
	assign s = {yq_q, 1'b0} + 35'(lft) + 35'(rgt);
	assign n = {1'b0, old_q, 19'd0} + 36'(s);

	assign hq = 37'(t_q) * 37'(RECIP3);
	assign h = hq[36:20];
	assign h_sat = (h > 17'(HMAX)) ? HMAX : h[OUT_H_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mag_q <= magnitude;
			wgt_q <= WGT_W'((WGT_W'(bin_q) + 1'b1) * WGT_W'(BIN_WGT));
		end
		if (cmd.prod) begin
			e_q <= E_W'(mag_q) * E_W'(wgt_q);
			right_q <= valid_q[bin_nxt] ? rd_data : '0;
		end
		if (cmd.norm) begin
			m_q <= xn[X_W-1 -: 31];
			p_q <= p;
			frac_q <= '0;
			old_q <= valid_q[bin_q] ? rd_data : '0;
		end
		if (cmd.sq) begin
			m_q <= mt[31] ? mt[31:1] : mt[30:0];
			frac_q <= {frac_q[14:0], mt[31]};
		end
		if (cmd.y1) prod1_q <= 32'(dh_q) * 32'(dl);
		if (cmd.y2) yq_q <= prod2[51:20];
		if (cmd.sum) t_q <= n[35:18];
		if (cmd.fin) begin
			idx_q <= bin_q;
			hout_q <= h_sat;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dh_q <= DH_RESET;
			bin_q <= '0;
			left_q <= '0;
			valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) dh_q <= cfg_data;
			if (cmd.fin) begin
				bin_q <= is_last ? '0 : bin_nxt;
				left_q <= {1'b0, h_sat};
				valid_q[bin_q] <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign bar_index = idx_q;
	assign bar_height = hout_q;
	assign last_bar = last_q;
endmodule

// File: rtl/spectrum_bar_smoother.sv
// top level of the spectrum bar smoother
// each bin passes through the prod, norm, sq, y1, y2, sum and fin states; fin waits while the result is stalled
// one bin is processed at a time; the squaring log unit takes 16 steps per bin
// the next input is taken while the previous result waits in the output register
// reset clears bar heights (per-bar valid bits), left height, bin counter, display height 480
module spectrum_bar_smoother (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sbs_pkg::DH_W-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sbs_pkg::MAG_W-1:0]     magnitude,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sbs_pkg::BIN_W-1:0]     bar_index,
	output logic [sbs_pkg::OUT_H_W-1:0]   bar_height,
	output logic                          last_bar
);
	import sbs_pkg::*;

	sbs_cmd_t  cmd;
	sbs_stat_t stat;

	assign cfg_ready = 1'b1;

	sbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sbs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.magnitude  (magnitude),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bar_index  (bar_index),
		.bar_height (bar_height),
		.last_bar   (last_bar)
	);
endmodule
